FILE: design/tamc_pkg.sv
// Shared types and constants for the threshold alarm menu controller.
`timescale 1ns / 1ps

package tamc_pkg;

    localparam int VALUE_WIDTH = 8;
    localparam int KEY_WIDTH   = 3;
    localparam int MODE_WIDTH  = 3;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [KEY_WIDTH-1:0]   t_key;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_MONITOR      = 3'd0,
        MODE_SET_HUM_MAX  = 3'd1,
        MODE_SET_HUM_MIN  = 3'd2,
        MODE_SET_TEMP_MAX = 3'd3,
        MODE_SET_TEMP_MIN = 3'd4,
        MODE_TEMP_ALARM   = 3'd5,
        MODE_HUM_ALARM    = 3'd6
    } t_mode;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam t_key KEY_NONE = 3'd0;
    localparam t_key KEY_OK   = 3'd1;
    localparam t_key KEY_INC  = 3'd2;
    localparam t_key KEY_DEC  = 3'd3;

    localparam t_value TEMP_UPPER_RST = VALUE_WIDTH'(30);
    localparam t_value TEMP_LOWER_RST = VALUE_WIDTH'(20);
    localparam t_value HUM_UPPER_RST  = VALUE_WIDTH'(75);
    localparam t_value HUM_LOWER_RST  = VALUE_WIDTH'(35);

endpackage

FILE: design/tamc_in_if.sv
// Input channel: key events and sensor ticks.
`timescale 1ns / 1ps

interface tamc_in_if;
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    tamc_pkg::t_key        key_code;
    tamc_pkg::t_value      temperature;
    tamc_pkg::t_value      humidity;

    modport source (output valid, output opcode, output key_code, output temperature,
                    output humidity, input ready);
    modport sink   (input valid, input opcode, input key_code, input temperature,
                    input humidity, output ready);
endinterface

FILE: design/tamc_out_if.sv
// Output channel: mode, limits and alarm flag after each beat.
`timescale 1ns / 1ps

interface tamc_out_if;
    logic                          valid;
    logic                          ready;
    logic [tamc_pkg::MODE_WIDTH-1:0] mode;
    tamc_pkg::t_value              temp_upper;
    tamc_pkg::t_value              temp_lower;
    tamc_pkg::t_value              hum_upper;
    tamc_pkg::t_value              hum_lower;
    logic                          alarm_active;

    modport source (output valid, output mode, output temp_upper, output temp_lower,
                    output hum_upper, output hum_lower, output alarm_active,
                    input ready);
    modport sink   (input valid, input mode, input temp_upper, input temp_lower,
                    input hum_upper, input hum_lower, input alarm_active,
                    output ready);
endinterface

FILE: design/threshold_alarm_menu_controller.sv
// An accepted beat passes from the input register to the result register, which offers it.
// Throughput: one beat per cycle while the sink is ready; the input register and the
// result register each advance whenever the stage after them is empty or being emptied.
// The mode update and the limit step are one short pass of compare and add or subtract.
// Reset (synchronous, active low) empties both stages, sets the mode to
// set max humidity and loads the default limits.
`timescale 1ns / 1ps

module threshold_alarm_menu_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tamc_in_if.sink           i_in,
    tamc_out_if.source        o_out
);

    // Input stage
    logic                   r_in_valid;
    logic                   r_opcode;
    tamc_pkg::t_key         r_key;
    tamc_pkg::t_value       r_temp;
    tamc_pkg::t_value       r_hum;

    // Controller state
    tamc_pkg::t_mode        r_mode;
    tamc_pkg::t_mode        n_mode;
    tamc_pkg::t_value       r_temp_upper;
    tamc_pkg::t_value       r_temp_lower;
    tamc_pkg::t_value       r_hum_upper;
    tamc_pkg::t_value       r_hum_lower;
    tamc_pkg::t_value       n_temp_upper;
    tamc_pkg::t_value       n_temp_lower;
    tamc_pkg::t_value       n_hum_upper;
    tamc_pkg::t_value       n_hum_lower;

    // Result stage
    logic                   r_out_valid;
    logic                   out_free;
    logic                   advance;

    function automatic tamc_pkg::t_value nudge(input tamc_pkg::t_value value,
                                               input tamc_pkg::t_key key);
        tamc_pkg::t_value result;
        result = value;
        if (key == tamc_pkg::KEY_INC) begin
            result = value + tamc_pkg::VALUE_WIDTH'(1);
        end else if (key == tamc_pkg::KEY_DEC) begin
            result = value - tamc_pkg::VALUE_WIDTH'(1);
        end
        return result;
    endfunction

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_opcode <= i_in.opcode;
            r_key    <= i_in.key_code;
            r_temp   <= i_in.temperature;
            r_hum    <= i_in.humidity;
        end
    end

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (r_opcode == tamc_pkg::OP_KEY) begin
            if (r_key != tamc_pkg::KEY_NONE) begin
                unique case (r_mode)
                    tamc_pkg::MODE_MONITOR: begin
                        if (r_key == tamc_pkg::KEY_OK) n_mode = tamc_pkg::MODE_SET_HUM_MAX;
                    end
                    tamc_pkg::MODE_SET_HUM_MAX: begin
                        if (r_key == tamc_pkg::KEY_OK) n_mode = tamc_pkg::MODE_SET_HUM_MIN;
                    end
                    tamc_pkg::MODE_SET_HUM_MIN: begin
                        if (r_key == tamc_pkg::KEY_OK) n_mode = tamc_pkg::MODE_SET_TEMP_MAX;
                    end
                    tamc_pkg::MODE_SET_TEMP_MAX: begin
                        if (r_key == tamc_pkg::KEY_OK) n_mode = tamc_pkg::MODE_SET_TEMP_MIN;
                    end
                    tamc_pkg::MODE_SET_TEMP_MIN: begin
                        if (r_key == tamc_pkg::KEY_OK) n_mode = tamc_pkg::MODE_MONITOR;
                    end
                    tamc_pkg::MODE_TEMP_ALARM: n_mode = tamc_pkg::MODE_SET_TEMP_MAX;
                    tamc_pkg::MODE_HUM_ALARM:  n_mode = tamc_pkg::MODE_SET_HUM_MAX;
                    default:                   n_mode = tamc_pkg::MODE_MONITOR;
                endcase
            end
        end else if (r_mode == tamc_pkg::MODE_MONITOR) begin
            // temperature window takes precedence over humidity
            if (r_temp < r_temp_lower || r_temp > r_temp_upper) begin
                n_mode = tamc_pkg::MODE_TEMP_ALARM;
            end else if (r_hum < r_hum_lower || r_hum > r_hum_upper) begin
                n_mode = tamc_pkg::MODE_HUM_ALARM;
            end
        end
    end

    // Limit edits: step only the limit of the current setting mode
    always_comb begin
        n_temp_upper = r_temp_upper;
        n_temp_lower = r_temp_lower;
        n_hum_upper  = r_hum_upper;
        n_hum_lower  = r_hum_lower;
        if (r_opcode == tamc_pkg::OP_KEY) begin
            unique case (r_mode)
                tamc_pkg::MODE_SET_HUM_MAX:  n_hum_upper  = nudge(r_hum_upper, r_key);
                tamc_pkg::MODE_SET_HUM_MIN:  n_hum_lower  = nudge(r_hum_lower, r_key);
                tamc_pkg::MODE_SET_TEMP_MAX: n_temp_upper = nudge(r_temp_upper, r_key);
                tamc_pkg::MODE_SET_TEMP_MIN: n_temp_lower = nudge(r_temp_lower, r_key);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= tamc_pkg::MODE_SET_HUM_MAX;
            r_temp_upper <= tamc_pkg::TEMP_UPPER_RST;
            r_temp_lower <= tamc_pkg::TEMP_LOWER_RST;
            r_hum_upper  <= tamc_pkg::HUM_UPPER_RST;
            r_hum_lower  <= tamc_pkg::HUM_LOWER_RST;
        end else if (advance) begin
            r_mode       <= n_mode;
            r_temp_upper <= n_temp_upper;
            r_temp_lower <= n_temp_lower;
            r_hum_upper  <= n_hum_upper;
            r_hum_lower  <= n_hum_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Hold the result beat while the sink stalls
    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_out.mode         <= n_mode;
            o_out.temp_upper   <= n_temp_upper;
            o_out.temp_lower   <= n_temp_lower;
            o_out.hum_upper    <= n_hum_upper;
            o_out.hum_lower    <= n_hum_lower;
            o_out.alarm_active <= (n_mode == tamc_pkg::MODE_TEMP_ALARM)
                               || (n_mode == tamc_pkg::MODE_HUM_ALARM);
        end
    end

    assign o_out.valid = r_out_valid;

endmodule
